// ----- design/drld_pkg.sv -----
// Shared types and constants for the data-run list decoder.
// Request payloads, parser event, end-status codes, register indexes.
// No dependencies.
`timescale 1ns / 1ps

package drld_pkg;

	localparam int MAX_FIELD_BYTES = 8;
	localparam int OUT_DEPTH = 4;

	typedef enum logic [2:0] {
		ST_RUNNING     = 3'd0,
		ST_ZERO_HEADER = 3'd1,
		ST_BUFFER_END  = 3'd2,
		ST_ZERO_LENGTH = 3'd3,
		ST_TRUNCATED   = 3'd4,
		ST_NEG_CLUSTER = 3'd5,
		ST_TOO_WIDE    = 3'd6
	} end_status_t;

	typedef enum logic [0:0] {
		CFG_CLUSTER_SIZE    = 1'b0,
		CFG_PARTITION_START = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] run_byte;
		logic       first_of_list;
		logic       last_of_buffer;
	} in_t;

	typedef struct packed {
		logic        extent_valid;
		logic [63:0] disk_offset;
		logic [63:0] extent_length;
		logic        list_done;
		end_status_t end_status;
	} out_t;

	typedef struct packed {
		logic        extent_valid;
		logic [63:0] cluster;
		logic [63:0] length;
		logic        list_done;
		end_status_t end_status;
	} event_t;

endpackage

// ----- design/drld_parser.sv -----
// Run-list byte parser: header, length and offset fields, running cluster.
// Registers one event per result-bearing byte. Depends on drld_pkg.
`timescale 1ns / 1ps

module drld_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  drld_pkg::in_t       byte_data,
	output logic                ev_valid_s1,
	output drld_pkg::event_t    ev_s1
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_OFFSET,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_e, phase_n;
	logic [3:0]  lbl_q, lbl_e, lbl_n;
	logic [3:0]  obl_q, obl_e, obl_n;
	logic [3:0]  osz_q, osz_e, osz_n;
	logic [2:0]  bpos_q, bpos_e, bpos_n;
	logic [63:0] lacc_q, lacc_e, lacc_n;
	logic [63:0] dacc_q, dacc_e, dacc_n;
	logic [63:0] rc_q, rc_e, rc_n;
	logic [63:0] lane, sign_mask, dfull, rc_sum;
	logic [3:0]  lsz, osz_h;
	logic        first, last, emit;
	drld_pkg::event_t ev;

	assign first = byte_data.first_of_list;
	assign last  = byte_data.last_of_buffer;
	assign lsz   = byte_data.run_byte[3:0];
	assign osz_h = byte_data.run_byte[7:4];

	always_comb begin
		phase_e = first ? PH_HEADER : phase_q;
		lbl_e   = first ? 4'd0 : lbl_q;
		obl_e   = first ? 4'd0 : obl_q;
		osz_e   = first ? 4'd0 : osz_q;
		bpos_e  = first ? 3'd0 : bpos_q;
		lacc_e  = first ? 64'd0 : lacc_q;
		dacc_e  = first ? 64'd0 : dacc_q;
		rc_e    = first ? 64'd0 : rc_q;
	end

	assign lane = {56'd0, byte_data.run_byte} << {bpos_e, 3'd0};

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sign_mask[8*i +: 8] = (4'(i) >= osz_e) ? 8'hFF : 8'h00;
		end
	end

	always_comb begin
		dfull = dacc_e | lane;
		if ((osz_e < 4'd8) && byte_data.run_byte[7] && (obl_e == 4'd1)) begin
			dfull = dfull | sign_mask;
		end
	end

	assign rc_sum = rc_e + dfull;

	always_comb begin
		phase_n = phase_e;
		lbl_n   = lbl_e;
		obl_n   = obl_e;
		osz_n   = osz_e;
		bpos_n  = bpos_e;
		lacc_n  = lacc_e;
		dacc_n  = dacc_e;
		rc_n    = rc_e;
		emit    = 1'b0;
		ev      = '0;
		ev.list_done  = 1'b1;
		ev.end_status = drld_pkg::ST_RUNNING;

		unique case (phase_e)
			PH_HEADER: begin
				emit    = 1'b1;
				phase_n = PH_DONE;
				priority if (byte_data.run_byte == 8'd0) begin
					ev.end_status = drld_pkg::ST_ZERO_HEADER;
				end else if (lsz == 4'd0) begin
					ev.end_status = drld_pkg::ST_ZERO_LENGTH;
				end else if (last) begin
					ev.end_status = drld_pkg::ST_TRUNCATED;
				end else if ((lsz > 4'(drld_pkg::MAX_FIELD_BYTES)) ||
				             (osz_h > 4'(drld_pkg::MAX_FIELD_BYTES))) begin
					ev.end_status = drld_pkg::ST_TOO_WIDE;
				end else begin
					emit    = 1'b0;
					phase_n = PH_LENGTH;
					lbl_n   = lsz;
					obl_n   = osz_h;
					osz_n   = osz_h;
					bpos_n  = 3'd0;
					lacc_n  = 64'd0;
					dacc_n  = 64'd0;
				end
			end
			PH_LENGTH: begin
				lacc_n = lacc_e | lane;
				bpos_n = bpos_e + 3'd1;
				lbl_n  = lbl_e - 4'd1;
				if (lbl_n == 4'd0 && osz_e == 4'd0) begin
					if (last) begin
						emit          = 1'b1;
						phase_n       = PH_DONE;
						ev.end_status = drld_pkg::ST_BUFFER_END;
					end else begin
						phase_n = PH_HEADER;
					end
				end else begin
					if (lbl_n == 4'd0) begin
						phase_n = PH_OFFSET;
						bpos_n  = 3'd0;
					end
					if (last) begin
						emit          = 1'b1;
						phase_n       = PH_DONE;
						ev.end_status = drld_pkg::ST_TRUNCATED;
					end
				end
			end
			PH_OFFSET: begin
				dacc_n = dfull;
				bpos_n = bpos_e + 3'd1;
				obl_n  = obl_e - 4'd1;
				if (obl_n == 4'd0) begin
					rc_n = rc_sum;
					emit = 1'b1;
					if (rc_sum[63]) begin
						phase_n       = PH_DONE;
						ev.end_status = drld_pkg::ST_NEG_CLUSTER;
					end else begin
						ev.extent_valid = 1'b1;
						ev.cluster      = rc_sum;
						ev.length       = lacc_e;
						ev.list_done    = last;
						ev.end_status   = last ? drld_pkg::ST_BUFFER_END
						                       : drld_pkg::ST_RUNNING;
						phase_n         = last ? PH_DONE : PH_HEADER;
					end
				end else if (last) begin
					emit          = 1'b1;
					phase_n       = PH_DONE;
					ev.end_status = drld_pkg::ST_TRUNCATED;
				end
			end
			PH_DONE: begin
				phase_n = PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			lbl_q       <= 4'd0;
			obl_q       <= 4'd0;
			osz_q       <= 4'd0;
			bpos_q      <= 3'd0;
			lacc_q      <= 64'd0;
			dacc_q      <= 64'd0;
			rc_q        <= 64'd0;
			ev_valid_s1 <= 1'b0;
		end else begin
			ev_valid_s1 <= accept && emit;
			if (accept) begin
				phase_q <= phase_n;
				lbl_q   <= lbl_n;
				obl_q   <= obl_n;
				osz_q   <= osz_n;
				bpos_q  <= bpos_n;
				lacc_q  <= lacc_n;
				dacc_q  <= dacc_n;
				rc_q    <= rc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1 <= ev;
		end
	end

endmodule

// ----- design/drld_scale.sv -----
// Extent scaling: cluster number and length times cluster size, plus base on the offset.
// Split 32x24 partial products registered, then summed. Depends on drld_pkg.
`timescale 1ns / 1ps

module drld_scale (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ev_valid_s1,
	input  drld_pkg::event_t ev_s1,
	input  logic [23:0]      cluster_size,
	input  logic [63:0]      partition_start,
	output logic             res_valid_s2,
	output drld_pkg::out_t   res
);

	logic [55:0] off_lo_s2, len_lo_s2;
	logic [31:0] off_hi_s2, len_hi_s2;
	logic        ext_s2, done_s2;
	drld_pkg::end_status_t status_s2;
	logic [63:0] off_sum, len_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else begin
			res_valid_s2 <= ev_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid_s1) begin
			off_lo_s2 <= {24'd0, ev_s1.cluster[31:0]} * {32'd0, cluster_size};
			off_hi_s2 <= ev_s1.cluster[63:32] * {8'd0, cluster_size};
			len_lo_s2 <= {24'd0, ev_s1.length[31:0]} * {32'd0, cluster_size};
			len_hi_s2 <= ev_s1.length[63:32] * {8'd0, cluster_size};
			ext_s2    <= ev_s1.extent_valid;
			done_s2   <= ev_s1.list_done;
			status_s2 <= ev_s1.end_status;
		end
	end

	assign off_sum = partition_start + {8'd0, off_lo_s2} + {off_hi_s2, 32'd0};
	assign len_sum = {8'd0, len_lo_s2} + {len_hi_s2, 32'd0};

	always_comb begin
		res.extent_valid  = ext_s2;
		res.disk_offset   = ext_s2 ? off_sum : 64'd0;
		res.extent_length = ext_s2 ? len_sum : 64'd0;
		res.list_done     = done_s2;
		res.end_status    = status_s2;
	end

endmodule

// ----- design/drld_outq.sv -----
// Result queue: small register FIFO in front of the result channel.
// Reports its fill level for credit checks. Depends on drld_pkg.
`timescale 1ns / 1ps

module drld_outq #(
	parameter int DEPTH = drld_pkg::OUT_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  drld_pkg::out_t               wr_data,
	input  logic                         rd_en,
	output drld_pkg::out_t               rd_data,
	output logic                         not_empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	drld_pkg::out_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign count     = count_q;
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- design/data_run_list_decoder.sv -----
// Top level of the data-run list decoder: config registers, parser,
// scaling pipeline and result queue. Depends on drld_pkg and all drld_ modules.
//
// channel  direction  handshake               payload
// byte     in         byte_valid/byte_ready   byte_data  (drld_pkg::in_t)
// ext      out        ext_valid/ext_ready     ext_data   (drld_pkg::out_t)
// cfg      in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One byte per cycle while byte_ready is high. A result passes the parser event and scale registers before the queue.
// The scaling pipeline (parser event, partial products, sum) is credited
// against the queue: byte_ready drops when queued plus in-flight results
// reach OUT_DEPTH; with OUT_DEPTH of 4 or more a ready sink sees no gaps.
// Reset is asynchronous: parser to header phase, registers to defaults.
`timescale 1ns / 1ps

module data_run_list_decoder #(
	parameter int OUT_DEPTH = drld_pkg::OUT_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  drld_pkg::in_t         byte_data,
	output logic                  ext_valid,
	input  logic                  ext_ready,
	output drld_pkg::out_t        ext_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  drld_pkg::cfg_reg_t    cfg_index,
	input  logic [63:0]           cfg_data
);

	localparam int CNT_W = $clog2(OUT_DEPTH+1);

	logic [23:0]      cluster_size_q;
	logic [63:0]      partition_start_q;
	logic             accept, ev_valid_s1, res_valid_s2;
	drld_pkg::event_t ev_s1;
	drld_pkg::out_t   res;
	logic [CNT_W-1:0] q_count;
	logic [CNT_W:0]   occ;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_size_q    <= 24'd4096;
			partition_start_q <= 64'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				drld_pkg::CFG_CLUSTER_SIZE:    cluster_size_q    <= cfg_data[23:0];
				drld_pkg::CFG_PARTITION_START: partition_start_q <= cfg_data;
			endcase
		end
	end

	assign occ = {1'b0, q_count} + (CNT_W+1)'(ev_valid_s1) + (CNT_W+1)'(res_valid_s2);
	assign byte_ready = (occ < (CNT_W+1)'(OUT_DEPTH));
	assign accept = byte_valid && byte_ready;

	drld_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.byte_data   (byte_data),
		.ev_valid_s1 (ev_valid_s1),
		.ev_s1       (ev_s1)
	);

	drld_scale u_scale (
		.clk             (clk),
		.arst_n          (arst_n),
		.ev_valid_s1     (ev_valid_s1),
		.ev_s1           (ev_s1),
		.cluster_size    (cluster_size_q),
		.partition_start (partition_start_q),
		.res_valid_s2    (res_valid_s2),
		.res             (res)
	);

	drld_outq #(
		.DEPTH (OUT_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (res_valid_s2),
		.wr_data   (res),
		.rd_en     (ext_valid && ext_ready),
		.rd_data   (ext_data),
		.not_empty (ext_valid),
		.count     (q_count)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (CNT_W+1)'(OUT_DEPTH))
		else $error("result queue overrun");

	a_stop_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		ext_valid && !ext_data.extent_valid |-> ext_data.list_done)
		else $error("non-extent result without list end");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ext_valid && !ext_data.extent_valid |->
		ext_data.disk_offset == 64'd0 && ext_data.extent_length == 64'd0)
		else $error("non-extent result carries data");

	a_extent_status: assert property (@(posedge clk) disable iff (!arst_n)
		ext_valid && ext_data.extent_valid |->
		(ext_data.list_done && ext_data.end_status == drld_pkg::ST_BUFFER_END) ||
		(!ext_data.list_done && ext_data.end_status == drld_pkg::ST_RUNNING))
		else $error("extent with wrong end status");
`endif

endmodule

// ----- test/data_run_list_decoder_tb.sv -----
// Testbench for data_run_list_decoder: directed reset-default, header and end-of-list cases, then random
// run lists checked against an in-bench model of the run-list parser and extent scaling.
// Depends on drld_pkg and the data_run_list_decoder RTL.
`timescale 1ns / 1ps

module data_run_list_decoder_tb;

	typedef enum logic [1:0] {
		SEEK_HEADER,
		TAKE_LENGTH,
		TAKE_OFFSET,
		LIST_ENDED
	} parse_phase_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_ready;
	drld_pkg::in_t      byte_data = '0;
	logic               ext_valid;
	logic               ext_ready = 1'b0;
	drld_pkg::out_t     ext_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	drld_pkg::cfg_reg_t cfg_index = drld_pkg::CFG_CLUSTER_SIZE;
	logic [63:0]        cfg_data = '0;

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int mismatches = 0;
	int list_bytes_sent = 0;

	drld_pkg::out_t pending_extents[$];
	logic [7:0]     list_buf[$];

	logic [23:0]  cluster_bytes = 24'd4096;
	logic [63:0]  part_base = '0;
	parse_phase_t phase = SEEK_HEADER;
	logic [3:0]   len_left = '0;
	logic [3:0]   off_left = '0;
	logic [3:0]   off_size = '0;
	logic [2:0]   byte_pos = '0;
	logic [63:0]  len_acc = '0;
	logic [63:0]  delta_acc = '0;
	logic [63:0]  cluster_no = '0;

	data_run_list_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data (byte_data),
		.ext_valid (ext_valid),
		.ext_ready (ext_ready),
		.ext_data  (ext_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		ext_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	task automatic flag_mismatch(string what, drld_pkg::out_t want, drld_pkg::out_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%0t %s: expected v=%b off=%h len=%h done=%b st=%0d,",
				" got v=%b off=%h len=%h done=%b st=%0d"},
				$time, what, want.extent_valid, want.disk_offset, want.extent_length,
				want.list_done, want.end_status, got.extent_valid, got.disk_offset,
				got.extent_length, got.list_done, got.end_status);
	endtask

	always @(posedge clk) begin
		if (arst_n && ext_valid && ext_ready) begin
			if (pending_extents.size() == 0) begin
				flag_mismatch("unexpected result", '0, ext_data);
			end else begin
				if (ext_data.extent_valid !== pending_extents[0].extent_valid
					|| ext_data.disk_offset !== pending_extents[0].disk_offset
					|| ext_data.extent_length !== pending_extents[0].extent_length
					|| ext_data.list_done !== pending_extents[0].list_done
					|| ext_data.end_status !== pending_extents[0].end_status)
					flag_mismatch("result mismatch", pending_extents[0], ext_data);
				void'(pending_extents.pop_front());
			end
		end
	end

	task automatic emit(logic valid, logic [63:0] off, logic [63:0] len, logic done,
		drld_pkg::end_status_t st);
		drld_pkg::out_t r;
		r.extent_valid = valid;
		r.disk_offset = off;
		r.extent_length = len;
		r.list_done = done;
		r.end_status = st;
		pending_extents.insert(pending_extents.size(), r);
	endtask

	task automatic end_list(drld_pkg::end_status_t st);
		phase = LIST_ENDED;
		emit(1'b0, '0, '0, 1'b1, st);
	endtask

	task automatic close_run(logic last);
		if (off_size == 0) begin
			if (last)
				end_list(drld_pkg::ST_BUFFER_END);
			else
				phase = SEEK_HEADER;
		end else begin
			cluster_no = cluster_no + delta_acc;
			if (cluster_no[63]) begin
				end_list(drld_pkg::ST_NEG_CLUSTER);
			end else begin
				phase = last ? LIST_ENDED : SEEK_HEADER;
				emit(1'b1, part_base + cluster_no * {40'd0, cluster_bytes},
					len_acc * {40'd0, cluster_bytes}, last,
					last ? drld_pkg::ST_BUFFER_END : drld_pkg::ST_RUNNING);
			end
		end
	endtask

	task automatic decode_run_byte(drld_pkg::in_t item);
		logic [7:0] b;
		logic       last;
		logic [3:0] lsz;
		logic [3:0] osz;
		b = item.run_byte;
		last = item.last_of_buffer;
		if (item.first_of_list) begin
			phase = SEEK_HEADER;
			len_left = '0;
			off_left = '0;
			off_size = '0;
			byte_pos = '0;
			len_acc = '0;
			delta_acc = '0;
			cluster_no = '0;
		end
		case (phase)
			SEEK_HEADER: begin
				lsz = b[3:0];
				osz = b[7:4];
				if (b == 8'h00)
					end_list(drld_pkg::ST_ZERO_HEADER);
				else if (lsz == 0)
					end_list(drld_pkg::ST_ZERO_LENGTH);
				else if (last)
					end_list(drld_pkg::ST_TRUNCATED);
				else if (lsz > drld_pkg::MAX_FIELD_BYTES || osz > drld_pkg::MAX_FIELD_BYTES)
					end_list(drld_pkg::ST_TOO_WIDE);
				else begin
					len_left = lsz;
					off_left = osz;
					off_size = osz;
					byte_pos = '0;
					len_acc = '0;
					delta_acc = '0;
					phase = TAKE_LENGTH;
				end
			end
			TAKE_LENGTH: begin
				len_acc = len_acc | ({56'd0, b} << (8 * byte_pos));
				byte_pos = byte_pos + 3'd1;
				len_left = len_left - 4'd1;
				if (len_left == 0 && off_size == 0) begin
					close_run(last);
				end else begin
					if (len_left == 0) begin
						phase = TAKE_OFFSET;
						byte_pos = '0;
					end
					if (last)
						end_list(drld_pkg::ST_TRUNCATED);
				end
			end
			TAKE_OFFSET: begin
				delta_acc = delta_acc | ({56'd0, b} << (8 * byte_pos));
				byte_pos = byte_pos + 3'd1;
				off_left = off_left - 4'd1;
				if (off_left == 0) begin
					if (off_size < 8 && b[7])
						delta_acc = delta_acc | (~64'd0 << (8 * off_size));
					close_run(last);
				end else if (last) begin
					end_list(drld_pkg::ST_TRUNCATED);
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_byte(logic [7:0] b, logic first, logic last);
		drld_pkg::in_t item;
		item = {b, first, last};
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= item;
		do @(posedge clk); while (!byte_ready);
		decode_run_byte(item);
	endtask

	task automatic write_reg(drld_pkg::cfg_reg_t idx, logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == drld_pkg::CFG_CLUSTER_SIZE)
			cluster_bytes = value[23:0];
		else
			part_base = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		byte_valid <= 1'b0;
		while (pending_extents.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic test_defaults_without_start();
		send_byte(8'h11, 1'b0, 1'b0);
		send_byte(8'h05, 1'b0, 1'b0);
		send_byte(8'h10, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h11, 1'b0, 1'b0);
	endtask

	task automatic test_header_checks();
		send_byte(8'h90, 1'b1, 1'b0);
		send_byte(8'h11, 1'b1, 1'b1);
		send_byte(8'h19, 1'b1, 1'b0);
		send_byte(8'h91, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b1, 1'b1);
	endtask

	task automatic test_run_endings();
		// sparse run closing the buffer
		send_byte(8'h01, 1'b1, 1'b0);
		send_byte(8'h07, 1'b0, 1'b1);
		// drop run cut short in its offset field
		send_byte(8'h21, 1'b1, 1'b0);
		send_byte(8'h03, 1'b0, 1'b0);
		send_byte(8'h05, 1'b0, 1'b1);
		// negative delta from cluster zero
		send_byte(8'h11, 1'b1, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		// extent on the final buffer byte
		send_byte(8'h11, 1'b1, 1'b0);
		send_byte(8'h02, 1'b0, 1'b0);
		send_byte(8'h7F, 1'b0, 1'b1);
	endtask

	task automatic test_random_lists(int src_pct, int sink_pct, logic [23:0] csize,
		logic [63:0] base, int n_bytes);
		int         target;
		int         last_start;
		int         lsz;
		int         osz;
		int         ending;
		logic       mark_last;
		logic [7:0] b;
		settle();
		write_reg(drld_pkg::CFG_CLUSTER_SIZE, {40'd0, csize});
		write_reg(drld_pkg::CFG_PARTITION_START, base);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		target = list_bytes_sent + n_bytes;
		while (list_bytes_sent < target) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					b = 8'($urandom_range(0, 255));
					send_byte(b, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
				end
			end else begin
				list_buf.delete();
				last_start = 0;
				repeat ($urandom_range(1, 5)) begin
					last_start = list_buf.size();
					lsz = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8)
						: $urandom_range(1, 3);
					if ($urandom_range(0, 5) == 0)
						osz = 0;
					else
						osz = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8)
							: $urandom_range(1, 3);
					list_buf.insert(list_buf.size(), {osz[3:0], lsz[3:0]});
					repeat (lsz) begin
						b = 8'($urandom_range(0, 255));
						list_buf.insert(list_buf.size(), b);
					end
					for (int i = 1; i <= osz; i++) begin
						b = 8'($urandom_range(0, 255));
						// keep most deltas forward so lists run long
						if (i == osz && $urandom_range(0, 3) != 0) begin
							b[7] = 1'b0;
							if (osz == 8)
								b[6] = 1'b0;
						end
						list_buf.insert(list_buf.size(), b);
					end
				end
				mark_last = 1'b1;
				ending = $urandom_range(0, 3);
				case (ending)
					0: begin
						list_buf.insert(list_buf.size(), 8'h00);
						mark_last = 1'($urandom_range(0, 1));
					end
					1: ;
					2: begin
						repeat ($urandom_range(1, list_buf.size() - last_start - 1))
							void'(list_buf.pop_back());
					end
					default: begin
						b = 8'($urandom_range(0, 255));
						list_buf.insert(list_buf.size(), b);
						mark_last = 1'($urandom_range(0, 1));
					end
				endcase
				foreach (list_buf[i])
					send_byte(list_buf[i], i == 0, mark_last && i == list_buf.size() - 1);
				list_bytes_sent += list_buf.size();
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_defaults_without_start();
		test_header_checks();
		test_run_endings();
		test_random_lists(14, 80, 24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 280);
		test_random_lists(80, 14, 24'd0, {$urandom, $urandom}, 280);
		test_random_lists(0, 0, 24'd1, 64'd0, 150);
		test_random_lists(0, 0, 24'($urandom_range(1, 24'hFFFFFF)), {$urandom, $urandom}, 150);
		settle();
		if (pending_extents.size() != 0) begin
			$display("%0d expected results never arrived", pending_extents.size());
			mismatches += pending_extents.size();
		end
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- data_run_list_decoder.f -----
design/drld_pkg.sv
design/drld_parser.sv
design/drld_scale.sv
design/drld_outq.sv
design/data_run_list_decoder.sv
test/data_run_list_decoder_tb.sv
